// ===== hdl/lmx_pkg.sv =====
package lmx_pkg;

  // Geometry of the 8x8 panel.
  localparam int unsigned COLS       = 8;
  localparam int unsigned ROWS       = 8;
  localparam int unsigned PIXELS     = ROWS * COLS;
  localparam int unsigned COL_W      = $clog2(COLS);
  localparam int unsigned ROW_W      = $clog2(ROWS);
  localparam int unsigned IDX_W      = $clog2(PIXELS);
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ROW_ORDER_W = ROWS * ROW_W;

  // Row order after reset: logical rows 0..7 drive physical rows 7,6,5,4,0,1,2,3.
  localparam logic [ROW_ORDER_W-1:0] ROW_ORDER_RESET = 24'h688977;

  // Pixel codes in the frame store.
  localparam logic [BYTE_W-1:0] PX_RED   = 8'd1;
  localparam logic [BYTE_W-1:0] PX_GREEN = 8'd2;
  localparam logic [BYTE_W-1:0] PX_BOTH  = 8'd3;

  // Command codes of an input word.
  typedef enum logic [1:0] {
    CMD_SPI     = 2'd0,
    CMD_CS_HIGH = 2'd1,
    CMD_SCAN    = 2'd2
  } cmd_t;

  // Control carried from the read stage to the result stage.
  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] rp_bank;
    logic [ROW_W-1:0] phys;
  } s1_t;

endpackage

// ===== hdl/lmx_if.sv =====
// Input word channel.
interface lmx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] spi_byte;

  modport source (output valid, output cmd, output spi_byte, input ready);
  modport sink   (input valid, input cmd, input spi_byte, output ready);
endinterface

// Result word channel.
interface lmx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] spi_reply;
  logic [7:0] red_bits;
  logic [7:0] green_bits;
  logic [7:0] row_drive;

  modport source (output valid, output kind, output spi_reply, output red_bits,
                  output green_bits, output row_drive, input ready);
  modport sink   (input valid, input kind, input spi_reply, input red_bits,
                  input green_bits, input row_drive, output ready);
endinterface

// Row order register write channel.
interface lmx_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/lmx_frame_store.sv =====
module lmx_frame_store (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   wr_en,
  input  logic [lmx_pkg::COL_W-1:0]              wr_bank,
  input  logic [lmx_pkg::ROW_W-1:0]              wr_row,
  input  logic [lmx_pkg::BYTE_W-1:0]             wr_data,
  input  logic                                   rd_en,
  input  logic [lmx_pkg::ROW_W-1:0]              rp_row,
  input  logic [lmx_pkg::ROW_W-1:0]              sc_row,
  output logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] rp_data,
  output logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] sc_data
);

  // One bank per column; each bank holds that column of every row.
  // Port A serves the SPI reply, port B the row scan.
  for (genvar b = 0; b < lmx_pkg::COLS; b++) begin : g_bank
    logic [lmx_pkg::BYTE_W-1:0] mem [lmx_pkg::ROWS];
    logic [lmx_pkg::ROWS-1:0]   vld;
    logic                       bank_we;

    assign bank_we = wr_en && (wr_bank == lmx_pkg::COL_W'(b));

    // Valid bits make a never-written pixel read as zero after reset.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld <= '0;
      end else if (bank_we) begin
        vld[wr_row] <= 1'b1;
      end
    end

    // Write port.
    always_ff @(posedge clk) begin
      if (bank_we) begin
        mem[wr_row] <= wr_data;
      end
    end

    // Registered read ports; they see the contents before this cycle's write.
    always_ff @(posedge clk) begin
      if (rd_en) begin
        rp_data[b] <= vld[rp_row] ? mem[rp_row] : '0;
        sc_data[b] <= vld[sc_row] ? mem[sc_row] : '0;
      end
    end
  end

endmodule

// ===== hdl/lmx_result.sv =====
module lmx_result (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s1_valid,
  input  lmx_pkg::s1_t                                  s1,
  input  logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] rp_data,
  input  logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] sc_data,
  output logic                                          s1_take,
  lmx_out_if.source                                     result
);

  logic [lmx_pkg::BYTE_W-1:0] reply_next;
  logic [lmx_pkg::COLS-1:0]   red_next;
  logic [lmx_pkg::COLS-1:0]   green_next;
  logic [lmx_pkg::ROWS-1:0]   drive_next;

  // The result register takes a new word when it is empty or being drained.
  assign s1_take = !result.valid || result.ready;

  // Build the result fields for the command in the read stage.
  always_comb begin
    reply_next = '0;
    red_next   = '0;
    green_next = '0;
    drive_next = '0;
    case (s1.kind)
      lmx_pkg::CMD_SPI: begin
        reply_next = rp_data[s1.rp_bank];
      end
      lmx_pkg::CMD_SCAN: begin
        for (int i = 0; i < lmx_pkg::COLS; i++) begin
          red_next[i]   = (sc_data[i] == lmx_pkg::PX_RED) ||
                          (sc_data[i] == lmx_pkg::PX_BOTH);
          green_next[i] = (sc_data[i] == lmx_pkg::PX_GREEN) ||
                          (sc_data[i] == lmx_pkg::PX_BOTH);
        end
        drive_next = lmx_pkg::ROWS'(1) << s1.phys;
      end
      default: begin
        reply_next = '0;
      end
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_take) begin
      result.valid <= s1_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (s1_valid && s1_take) begin
      result.kind       <= s1.kind;
      result.spi_reply  <= reply_next;
      result.red_bits   <= red_next;
      result.green_bits <= green_next;
      result.row_drive  <= drive_next;
    end
  end

endmodule

// ===== hdl/spi_led_matrix_frame_scanner.sv =====
// A word is registered in the read stage, then in the result register. Throughput:
// one word per cycle unless the result stalls; the frame store has a reply read port,
// a scan read port and a write port per column bank, so words never wait for a port.
// Reset (synchronous, active high) empties the pipeline, sets the write index and
// scan row to zero, loads the default row order and clears the frame store at once.
module spi_led_matrix_frame_scanner (
  input  logic       clk,
  input  logic       rst,
  lmx_in_if.sink     item,
  lmx_cfg_if.sink    cfg,
  lmx_out_if.source  result
);

  logic                                          accept;
  logic                                          is_spi;
  logic [lmx_pkg::IDX_W-1:0]                     write_index;
  logic [lmx_pkg::IDX_W-1:0]                     write_index_next;
  logic [lmx_pkg::IDX_W-1:0]                     index_plus;
  logic [lmx_pkg::ROW_W-1:0]                     scan_row;
  logic [lmx_pkg::ROW_ORDER_W-1:0]               row_order;
  logic                                          s1_valid;
  lmx_pkg::s1_t                                  s1;
  logic                                          s1_take;
  logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] rp_data;
  logic [lmx_pkg::COLS-1:0][lmx_pkg::BYTE_W-1:0] sc_data;

  // Input handshake: the read stage frees up when it is empty or moves on.
  assign item.ready = !s1_valid || s1_take;
  assign accept     = item.valid && item.ready;
  assign is_spi     = item.cmd == lmx_pkg::CMD_SPI;
  assign index_plus = write_index + lmx_pkg::IDX_W'(1);
  assign cfg.ready  = 1'b1;

  // Write index: advances per SPI word, back to zero on chip select release.
  always_comb begin
    write_index_next = write_index;
    case (item.cmd)
      lmx_pkg::CMD_SPI:     write_index_next = index_plus;
      lmx_pkg::CMD_CS_HIGH: write_index_next = '0;
      default:              write_index_next = write_index;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
      scan_row    <= '0;
    end else if (accept) begin
      write_index <= write_index_next;
      if (item.cmd == lmx_pkg::CMD_SCAN) begin
        scan_row <= scan_row + lmx_pkg::ROW_W'(1);
      end
    end
  end

  // Row order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_order <= lmx_pkg::ROW_ORDER_RESET;
    end else if (cfg.valid) begin
      row_order <= cfg.data;
    end
  end

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.kind    <= item.cmd;
      s1.rp_bank <= ~index_plus[lmx_pkg::COL_W-1:0];
      s1.phys    <= row_order[lmx_pkg::ROW_W*scan_row +: lmx_pkg::ROW_W];
    end
  end

  // Frame store: column mirrored on write, reply read at the next mirrored slot.
  lmx_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && is_spi),
    .wr_bank (~write_index[lmx_pkg::COL_W-1:0]),
    .wr_row  (write_index[lmx_pkg::IDX_W-1:lmx_pkg::COL_W]),
    .wr_data (item.spi_byte),
    .rd_en   (accept),
    .rp_row  (index_plus[lmx_pkg::IDX_W-1:lmx_pkg::COL_W]),
    .sc_row  (scan_row),
    .rp_data (rp_data),
    .sc_data (sc_data)
  );

  lmx_result u_result (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1       (s1),
    .rp_data  (rp_data),
    .sc_data  (sc_data),
    .s1_take  (s1_take),
    .result   (result)
  );

  // A scan result drives exactly one row; other results drive none.
  a_scan_onehot: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind == lmx_pkg::CMD_SCAN) |-> $onehot(result.row_drive))
    else $error("scan result does not drive exactly one row");

  a_idle_dark: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.kind != lmx_pkg::CMD_SCAN) |->
      (result.row_drive == '0) && (result.red_bits == '0) && (result.green_bits == '0))
    else $error("non-scan result lights lamps");

  // The write index steps by one per accepted SPI word.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    accept && is_spi |=> write_index == $past(index_plus))
    else $error("write index did not advance");

  // Chip select release returns the index to the first pixel.
  a_cs_clear: assert property (@(posedge clk) disable iff (rst)
    accept && (item.cmd == lmx_pkg::CMD_CS_HIGH) |=> write_index == '0)
    else $error("write index not cleared by chip select release");

  // A waiting result holds the read stage in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_take |=> s1_valid && $stable(s1))
    else $error("read stage changed while stalled");

endmodule
